>>> sv/u8u16_pkg.sv
`timescale 1ns / 1ps
package u8u16_pkg;

  localparam int unsigned MaxUnits = 4;

  localparam logic [15:0] Replacement = 16'hFFFD;
  localparam logic [7:0]  LeadMin     = 8'hC2;
  localparam logic [7:0]  LeadMax     = 8'hF4;
  localparam logic [7:0]  Lead3Min    = 8'hE0;
  localparam logic [7:0]  Lead4Min    = 8'hF0;
  localparam logic [7:0]  LeadE0      = 8'hE0;
  localparam logic [7:0]  LeadED      = 8'hED;
  localparam logic [7:0]  LeadF0      = 8'hF0;
  localparam logic [7:0]  LeadF4      = 8'hF4;
  localparam logic [7:0]  SecondA0    = 8'hA0;
  localparam logic [7:0]  Second90    = 8'h90;
  localparam logic [7:0]  AsciiLimit  = 8'h80;
  localparam logic [1:0]  ContTag     = 2'b10;
  localparam logic [20:0] PlaneOne    = 21'h10000;
  localparam logic [15:0] HighSurr    = 16'hD800;
  localparam logic [15:0] LowSurr     = 16'hDC00;

  typedef logic [15:0] unit_t;
  typedef logic [2:0]  unit_cnt_t;

endpackage

>>> sv/utf8_to_utf16_transcoder_unit.sv
`timescale 1ns / 1ps
// UTF-8 to UTF-16 transcoder.
//
// Input channel (in_valid/in_ready): one UTF-8 byte per request in in_byte,
// with end_of_string high on the string's final byte. Output channel
// (out_valid/out_ready): one UTF-16 code unit per request, is_replacement
// high when the unit is U+FFFD standing for a bad or cut-off byte, last_unit
// high on the final unit of the string. Surrogate pairs come high half first.
//
// The units released by a byte appear in the cycle after it is taken.
// Throughput, with out_ready high: one byte per cycle while each byte
// releases at most one unit. A byte that releases k units (k up to 4, on
// error flushes or a surrogate pair) holds the input while the register
// drains one unit per cycle with out_ready high until its last unit leaves.
//
// Reset clears the open sequence and empties the result register. When the
// receiver stalls, the pending units hold in the result register and in_ready
// drops whenever the register holds a unit that is not leaving this cycle.
module utf8_to_utf16_transcoder_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_string,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8u16_pkg::unit_t     code_unit,
  output logic                 is_replacement,
  output logic                 last_unit
);
  import u8u16_pkg::*;

  // Open sequence state
  logic [7:0]  pend_lead;
  logic [1:0]  pend_cnt;
  logic [11:0] pend_pay;
  logic [7:0]  pend_lead_next;
  logic [1:0]  pend_cnt_next;
  logic [11:0] pend_pay_next;

  // Result register: units shift down as they leave
  unit_t       q_code [MaxUnits];
  logic [MaxUnits-1:0] q_repl;
  unit_cnt_t   q_cnt;
  logic        q_last;

  // Decoded bundle for the byte at the input
  unit_t       b_code [MaxUnits];
  logic [MaxUnits-1:0] b_repl;
  unit_cnt_t   b_cnt;

  logic        in_fire;
  logic        out_fire;

  logic        has_pend;
  logic [1:0]  need;
  logic        ok;
  logic        complete;
  logic        fresh;
  logic [20:0] scalar;
  logic [19:0] supp;
  logic        fresh_ascii;
  logic        fresh_lead;
  logic [1:0]  flush1;
  logic        do_flush2;
  logic [1:0]  flush2;

  assign out_valid      = (q_cnt != '0);
  assign code_unit      = q_code[0];
  assign is_replacement = q_repl[0];
  assign last_unit      = q_last && (q_cnt == unit_cnt_t'(1));

  assign out_fire = out_valid && out_ready;
  // Take a new byte once the result register empties this cycle
  assign in_ready = (q_cnt == '0) || ((q_cnt == unit_cnt_t'(1)) && out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    has_pend = (pend_lead != '0);
    if (pend_lead < Lead3Min) begin
      need = 2'd1;
    end else if (pend_lead < Lead4Min) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end

    ok = (in_byte[7:6] == ContTag);
    if (pend_cnt == 2'd0) begin
      if (pend_lead == LeadE0 && in_byte <  SecondA0) ok = 1'b0;
      if (pend_lead == LeadED && in_byte >= SecondA0) ok = 1'b0;
      if (pend_lead == LeadF0 && in_byte <  Second90) ok = 1'b0;
      if (pend_lead == LeadF4 && in_byte >= Second90) ok = 1'b0;
    end
    if (pend_cnt >= need) ok = 1'b0;

    complete = has_pend && ok && ((pend_cnt + 2'd1) == need);
    fresh    = !has_pend || !ok;

    case (need)
      2'd1:    scalar = {10'd0, pend_lead[4:0], in_byte[5:0]};
      2'd2:    scalar = {5'd0, pend_lead[3:0], pend_pay[5:0], in_byte[5:0]};
      default: scalar = {pend_lead[2:0], pend_pay, in_byte[5:0]};
    endcase
    supp = 20'(scalar - PlaneOne);

    fresh_ascii = (in_byte < AsciiLimit);
    fresh_lead  = (in_byte >= LeadMin) && (in_byte <= LeadMax);
    flush1      = (has_pend && !ok) ? pend_cnt : 2'd0;

    // Sequence state after this byte
    pend_lead_next = pend_lead;
    pend_cnt_next  = pend_cnt;
    pend_pay_next  = pend_pay;
    if (complete) begin
      pend_lead_next = '0;
      pend_cnt_next  = '0;
      pend_pay_next  = '0;
    end else if (fresh) begin
      pend_lead_next = fresh_lead ? in_byte : 8'd0;
      pend_cnt_next  = '0;
      pend_pay_next  = '0;
    end else begin
      pend_cnt_next  = pend_cnt + 2'd1;
      pend_pay_next  = {pend_pay[5:0], in_byte[5:0]};
    end

    // A string ending with an open sequence flushes it
    do_flush2 = end_of_string && (pend_lead_next != '0);
    flush2    = pend_cnt_next;
    if (end_of_string) begin
      pend_lead_next = '0;
      pend_cnt_next  = '0;
      pend_pay_next  = '0;
    end

    // Build the bundle: leading flush, middle unit(s), trailing flush
    for (int k = 0; k < MaxUnits; k++) begin
      b_code[k] = Replacement;
    end
    b_repl = '0;
    b_cnt  = '0;

    if (has_pend && !ok) begin
      b_repl[b_cnt[1:0]] = 1'b1;
      b_cnt = b_cnt + unit_cnt_t'(1);
      for (int k = 0; k < 2; k++) begin
        if (k < int'(flush1)) begin
          b_repl[b_cnt[1:0]] = 1'b1;
          b_cnt = b_cnt + unit_cnt_t'(1);
        end
      end
    end

    if (complete) begin
      if (scalar[20:16] == '0) begin
        b_code[b_cnt[1:0]] = scalar[15:0];
        b_cnt = b_cnt + unit_cnt_t'(1);
      end else begin
        b_code[b_cnt[1:0]] = HighSurr + {6'd0, supp[19:10]};
        b_cnt = b_cnt + unit_cnt_t'(1);
        b_code[b_cnt[1:0]] = LowSurr + {6'd0, supp[9:0]};
        b_cnt = b_cnt + unit_cnt_t'(1);
      end
    end else if (fresh) begin
      if (fresh_ascii) begin
        b_code[b_cnt[1:0]] = {8'd0, in_byte};
        b_cnt = b_cnt + unit_cnt_t'(1);
      end else if (!fresh_lead) begin
        b_repl[b_cnt[1:0]] = 1'b1;
        b_cnt = b_cnt + unit_cnt_t'(1);
      end
    end

    if (do_flush2) begin
      b_repl[b_cnt[1:0]] = 1'b1;
      b_cnt = b_cnt + unit_cnt_t'(1);
      for (int k = 0; k < 2; k++) begin
        if (k < int'(flush2)) begin
          b_repl[b_cnt[1:0]] = 1'b1;
          b_cnt = b_cnt + unit_cnt_t'(1);
        end
      end
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_lead <= '0;
      pend_cnt  <= '0;
      pend_pay  <= '0;
    end else if (in_fire) begin
      pend_lead <= pend_lead_next;
      pend_cnt  <= pend_cnt_next;
      pend_pay  <= pend_pay_next;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt  <= '0;
      q_last <= 1'b0;
    end else if (in_fire) begin
      q_cnt  <= b_cnt;
      q_last <= end_of_string;
    end else if (out_fire) begin
      q_cnt  <= q_cnt - unit_cnt_t'(1);
    end
  end

  // Result register payload: load a new bundle or advance one unit
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_code <= b_code;
      q_repl <= b_repl;
    end else if (out_fire) begin
      for (int k = 0; k < MaxUnits - 1; k++) begin
        q_code[k] <= q_code[k+1];
      end
      q_repl <= {1'b0, q_repl[MaxUnits-1:1]};
    end
  end

  // The final byte of a string always releases at least one unit
  a_eos_gives_unit: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_string |=> out_valid)
    else $error("end of string released no unit");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= unit_cnt_t'(MaxUnits))
    else $error("result register overfilled");

  a_lead_range: assert property (@(posedge clk) disable iff (rst)
    pend_lead != '0 |-> (pend_lead >= LeadMin) && (pend_lead <= LeadMax))
    else $error("held lead outside C2..F4");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    pend_lead == '0 |-> (pend_cnt == '0) && (pend_pay == '0))
    else $error("continuation state held with no open sequence");

  a_cnt_below_need: assert property (@(posedge clk) disable iff (rst)
    pend_cnt != 2'd3)
    else $error("too many held continuation bytes");

endmodule

>>> dv/utf8_to_utf16_transcoder_unit_test.sv
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder_unit_test;
  import u8u16_pkg::*;

  // Generous bound: every byte flushing four units, each unit waiting out
  // the longest receiver stall, plus the long hold-offs and sender gaps.
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RandomBytes = 500;
  localparam int unsigned HoldOffCycles = 250;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    bit         drain;   // wait for every expected unit before offering
  } byte_req_t;

  typedef struct {
    logic [15:0] code;
    logic        repl;
    logic        last;
  } utf16_unit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  unit_t       code_unit;
  logic        is_replacement;
  logic        last_unit;

  byte_req_t   byte_reqs[$];
  utf16_unit_t units_expected[$];
  logic [7:0]  str_bytes[$];
  logic [7:0]  seq_bytes[$];
  int unsigned mismatches = 0;

  // Decoder state mirrored by the predictor.
  logic [7:0]  held_lead = 8'h00;
  logic [1:0]  held_cnt = 2'd0;
  logic [11:0] held_bits = 12'h000;
  int unsigned step_units;

  utf8_to_utf16_transcoder_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .end_of_string  (end_of_string),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_unit      (code_unit),
    .is_replacement (is_replacement),
    .last_unit      (last_unit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: decode one byte and append the units it releases.
  // ---------------------------------------------------------------------------
  task automatic add_unit(input logic [15:0] code, input logic repl);
    utf16_unit_t u;
    u.code = code;
    u.repl = repl;
    u.last = 1'b0;
    units_expected.push_back(u);
    step_units++;
  endtask

  // Split code points above the BMP into a surrogate pair, high half first.
  task automatic add_scalar(input int unsigned val);
    int unsigned v;
    if (val <= 'hFFFF) begin
      add_unit(16'(val), 1'b0);
    end else begin
      v = (val - int'(PlaneOne)) & 'hFFFFF;
      add_unit(HighSurr + 16'(v >> 10), 1'b0);
      add_unit(LowSurr + 16'(v & 'h3FF), 1'b0);
    end
  endtask

  // Give one replacement per held byte and drop the open sequence.
  task automatic flush_held();
    if (held_lead != 8'h00) begin
      add_unit(Replacement, 1'b1);
      for (int k = 0; k < int'(held_cnt); k++) add_unit(Replacement, 1'b1);
    end
    held_lead = 8'h00;
    held_cnt  = 2'd0;
    held_bits = 12'h000;
  endtask

  task automatic decode_new(input logic [7:0] b);
    if (b < AsciiLimit) begin
      add_unit({8'h00, b}, 1'b0);
    end else if (b >= LeadMin && b <= LeadMax) begin
      held_lead = b;
      held_cnt  = 2'd0;
      held_bits = 12'h000;
    end else begin
      add_unit(Replacement, 1'b1);
    end
  endtask

  task automatic predict_units(input logic [7:0] b, input logic eos);
    int unsigned need;
    int unsigned lmask;
    int unsigned val;
    logic        ok;
    step_units = 0;
    if (held_lead != 8'h00) begin
      need = (held_lead < Lead3Min) ? 1 : ((held_lead < Lead4Min) ? 2 : 3);
      ok = (b[7:6] == ContTag);
      // Second-byte restrictions that reject overlongs, surrogates and
      // code points past the top of Unicode.
      if (held_cnt == 2'd0) begin
        if (held_lead == LeadE0 && b < SecondA0) ok = 1'b0;
        if (held_lead == LeadED && b >= SecondA0) ok = 1'b0;
        if (held_lead == LeadF0 && b < Second90) ok = 1'b0;
        if (held_lead == LeadF4 && b >= Second90) ok = 1'b0;
      end
      if (int'(held_cnt) >= need) ok = 1'b0;
      if (ok) begin
        if (int'(held_cnt) + 1 == need) begin
          lmask = (need == 1) ? 'h1F : ((need == 2) ? 'h0F : 'h07);
          val = ((int'(held_lead) & lmask) << (6 * need)) | (int'(held_bits) << 6)
              | int'(b[5:0]);
          held_lead = 8'h00;
          held_cnt  = 2'd0;
          held_bits = 12'h000;
          add_scalar(val);
        end else begin
          held_bits = {held_bits[5:0], b[5:0]};
          held_cnt  = held_cnt + 2'd1;
        end
      end else begin
        // Bad continuation: flush what is held, then decode the byte afresh.
        flush_held();
        decode_new(b);
      end
    end else begin
      decode_new(b);
    end
    // End of string: a cut-off sequence flushes, and the last unit is marked.
    if (eos) begin
      flush_held();
      if (step_units != 0) units_expected[$].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_length(input int unsigned busy_pct);
    int unsigned r = $urandom_range(0, 99);
    if (r >= busy_pct) return 0;
    if (r < busy_pct * 7 / 10) return $urandom_range(1, 3);
    if (r < busy_pct * 95 / 100) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_req(input logic [7:0] data, input logic eos);
    byte_req_t req;
    req.data  = data;
    req.eos   = eos;
    req.drain = 1'b0;
    byte_reqs.push_back(req);
  endtask

  // Encode one scalar value as well-formed UTF-8 into seq_bytes.
  task automatic encode_cp(input int unsigned cp);
    seq_bytes.delete();
    if (cp < 'h80) begin
      seq_bytes.push_back(8'(cp));
    end else if (cp < 'h800) begin
      seq_bytes.push_back(8'('hC0 | (cp >> 6)));
      seq_bytes.push_back(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      seq_bytes.push_back(8'('hE0 | (cp >> 12)));
      seq_bytes.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
      seq_bytes.push_back(8'('h80 | (cp & 'h3F)));
    end else begin
      seq_bytes.push_back(8'('hF0 | (cp >> 18)));
      seq_bytes.push_back(8'('h80 | ((cp >> 12) & 'h3F)));
      seq_bytes.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
      seq_bytes.push_back(8'('h80 | (cp & 'h3F)));
    end
  endtask

  function automatic int unsigned pick_cp();
    int unsigned cp;
    case ($urandom_range(0, 9))
      0, 1, 2: cp = $urandom_range(0, 'h7F);
      3, 4:    cp = $urandom_range('h80, 'h7FF);
      5, 6: begin
        cp = $urandom_range('h800, 'hFFFF);
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h1000;
      end
      7, 8:    cp = $urandom_range('h10000, 'h10FFFF);
      default: begin
        case ($urandom_range(0, 9))
          0: cp = 'h0;
          1: cp = 'h7F;
          2: cp = 'h80;
          3: cp = 'h7FF;
          4: cp = 'h800;
          5: cp = 'hD7FF;
          6: cp = 'hE000;
          7: cp = 'hFFFF;
          8: cp = 'h10000;
          default: cp = 'h10FFFF;
        endcase
      end
    endcase
    return cp;
  endfunction

  // Append one random element to the string: mostly valid characters, the
  // rest cut-off sequences, rejected second bytes and raw noise.
  task automatic add_element();
    int unsigned r = $urandom_range(0, 19);
    int unsigned keep;
    logic [7:0]  b;
    if (r < 12) begin
      encode_cp(pick_cp());
      foreach (seq_bytes[i]) str_bytes.push_back(seq_bytes[i]);
    end else if (r < 14) begin
      encode_cp(pick_cp() | 'h80);
      keep = $urandom_range(1, seq_bytes.size() - 1);
      for (int i = 0; i < int'(keep); i++) str_bytes.push_back(seq_bytes[i]);
    end else if (r < 16) begin
      case ($urandom_range(0, 4))
        0: begin str_bytes.push_back(LeadE0); str_bytes.push_back(8'($urandom_range('h80, 'h9F))); end
        1: begin str_bytes.push_back(LeadED); str_bytes.push_back(8'($urandom_range('hA0, 'hBF))); end
        2: begin str_bytes.push_back(LeadF0); str_bytes.push_back(8'($urandom_range('h80, 'h8F))); end
        3: begin str_bytes.push_back(LeadF4); str_bytes.push_back(8'($urandom_range('h90, 'hBF))); end
        default: begin
          str_bytes.push_back(8'($urandom_range(LeadMin, LeadMax)));
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == ContTag) b[6] = 1'b1;
          str_bytes.push_back(b);
        end
      endcase
    end else if (r < 19) begin
      str_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) str_bytes.push_back(8'($urandom_range('h80, 'hC1)));
      else str_bytes.push_back(8'($urandom_range('hF5, 'hFF)));
    end
  endtask

  // Move the built string into the request queue, end_of_string on its last byte.
  task automatic queue_string(input bit drain);
    byte_req_t req;
    foreach (str_bytes[i]) begin
      req.data  = str_bytes[i];
      req.eos   = (i == str_bytes.size() - 1);
      req.drain = drain && (i == 0);
      byte_reqs.push_back(req);
    end
    str_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer one request at a time, with random gaps between them.
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;
  int unsigned send_tick = 0;
  int unsigned reqs_taken = 0;

  always @(posedge clk) begin
    byte_req_t req;
    if (rst) begin
      in_valid      <= 1'b0;
      in_byte       <= 8'h00;
      end_of_string <= 1'b0;
      send_gap = 0;
    end else begin
      send_tick++;
      // Predict at the accepting edge, before any unit of this byte can leave.
      if (in_valid && in_ready) begin
        predict_units(in_byte, end_of_string);
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_reqs.size() != 0 &&
                     !(byte_reqs[0].drain && units_expected.size() != 0)) begin
          req = byte_reqs.pop_front();
          in_byte       <= req.data;
          end_of_string <= req.eos;
          in_valid      <= 1'b1;
          // Alternate stretches of back-to-back requests with gappy ones.
          send_gap = (send_tick[9:8] == 2'b00) ? 0 : idle_length(40);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted unit against the oldest expectation.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned units_seen = 0;
  int unsigned recv_tick = 0;

  always @(posedge clk) begin
    utf16_unit_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      recv_tick++;
      if (out_valid && out_ready) begin
        units_seen++;
        if (units_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected unit: expected none, got code_unit %h", $time, code_unit);
        end else begin
          want = units_expected.pop_front();
          if (code_unit !== want.code) begin
            mismatches++;
            $display("%0t: code_unit expected %h, got %h", $time, want.code, code_unit);
          end
          if (is_replacement !== want.repl) begin
            mismatches++;
            $display("%0t: is_replacement expected %b, got %b", $time, want.repl,
                     is_replacement);
          end
          if (last_unit !== want.last) begin
            mismatches++;
            $display("%0t: last_unit expected %b, got %b", $time, want.last, last_unit);
          end
        end
        // Hold off for a long stretch so the block fills and stalls its input.
        if (units_seen == 40 || units_seen == 350) hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = (recv_tick[9:8] == 2'b01) ? 0 : idle_length(25);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned strings_built;
    int unsigned reqs_total;
    // Directed: null byte, ASCII top, the smallest sequences of each length,
    // the second-byte limits, both ends of the supplementary planes, a
    // rejected E0 second byte, a three-byte flush, an invalid lead and a
    // sequence cut off at the end of the string.
    push_req(8'h00, 1'b1);
    push_req(8'h7F, 1'b0);
    push_req(8'hC2, 1'b0); push_req(8'h80, 1'b0);
    push_req(8'hE0, 1'b0); push_req(8'hA0, 1'b0); push_req(8'h80, 1'b0);
    push_req(8'hED, 1'b0); push_req(8'h9F, 1'b0); push_req(8'hBF, 1'b1);
    push_req(8'hF0, 1'b0); push_req(8'h90, 1'b0); push_req(8'h80, 1'b0);
    push_req(8'h80, 1'b0);
    push_req(8'hF4, 1'b0); push_req(8'h8F, 1'b0); push_req(8'hBF, 1'b0);
    push_req(8'hBF, 1'b1);
    push_req(8'hE0, 1'b0); push_req(8'h9F, 1'b0);
    push_req(8'hF0, 1'b0); push_req(8'h90, 1'b0); push_req(8'h80, 1'b0);
    push_req(8'h41, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'hE2, 1'b0); push_req(8'h82, 1'b1);

    // Random strings; now and then pause the sender until all units are in.
    strings_built = 0;
    while (byte_reqs.size() < RandomBytes + 27) begin
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 6))
        add_element();
      queue_string(strings_built % 40 == 0);
      strings_built++;
    end
    reqs_total = byte_reqs.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: wait until every request is taken and every unit has arrived,
    // then give the block a few cycles to show any stray unit.
    while (reqs_taken != reqs_total || units_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && units_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/u8u16_pkg.sv
sv/utf8_to_utf16_transcoder_unit.sv
dv/utf8_to_utf16_transcoder_unit_test.sv
